>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int STATUS_BITS  = 2;

    localparam int S_DATA_BITS  = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = KEY_BITS + PAYLOAD_BITS + CNT_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_DROPPED  = 2'd3;

    typedef logic [KEY_BITS-1:0]     key_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [CNT_BITS-1:0]     count_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

>>> rtl/core/stable_priority_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid / s_tready  tuser: req_type; tdata: item_key, item_payload
// m_        out        m_tvalid / m_tready  tuser: status; tdata: out_key, out_payload, occupancy
//
// One item per cycle while m_tready allows it: every cell compares its key with the new key at once and
// the whole chain shifts in the same cycle; the result appears in the cycle after.
// The result sits in an output register; a new item is taken while it is empty
// or being taken in the same cycle, so a low m_tready stalls the input side.
// Reset clears the entry count and the output valid; cell contents need no reset.

module stable_priority_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spq_pkg::S_DATA_BITS-1:0]     s_tdata,  // item_key, item_payload
    input  logic                                s_tuser,  // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spq_pkg::M_DATA_BITS-1:0]     m_tdata,  // out_key, out_payload, occupancy
    output logic [spq_pkg::STATUS_BITS-1:0]     m_tuser   // status
);
    import spq_pkg::*;

    key_t       new_key;
    payload_t   new_payload;
    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    count_t     count_reg, count_next;
    logic       out_valid_reg;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    key_t       out_key_reg, out_key_next;
    payload_t   out_payload_reg, out_payload_next;

    key_t       cell_key     [DEPTH];
    payload_t   cell_payload [DEPTH];
    logic       cell_le      [DEPTH];
    logic       cell_occ     [DEPTH];

    assign new_key     = s_tdata[KEY_BITS-1:0];
    assign new_payload = s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == count_t'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.push = accept && (s_tuser == REQ_ENQ) && !full;
    assign ctrl.pop  = accept && (s_tuser == REQ_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            assign cell_occ[i] = (count_t'(i) < count_reg);

            if (i == 0) begin : g_head
                spq_cell u_cell (
                    .aclk          (aclk),
                    .ctrl          (ctrl),
                    .new_key       (new_key),
                    .new_payload   (new_payload),
                    .left_key      (new_key),
                    .left_payload  (new_payload),
                    .left_le       (1'b1),
                    .right_key     (cell_key[1]),
                    .right_payload (cell_payload[1]),
                    .occupied      (cell_occ[0]),
                    .key           (cell_key[0]),
                    .payload       (cell_payload[0]),
                    .le            (cell_le[0])
                );
            end else if (i == DEPTH - 1) begin : g_tail
                // Past the tail there is never an entry to shift in.
                spq_cell u_cell (
                    .aclk          (aclk),
                    .ctrl          (ctrl),
                    .new_key       (new_key),
                    .new_payload   (new_payload),
                    .left_key      (cell_key[i-1]),
                    .left_payload  (cell_payload[i-1]),
                    .left_le       (cell_le[i-1]),
                    .right_key     ('0),
                    .right_payload ('0),
                    .occupied      (cell_occ[i]),
                    .key           (cell_key[i]),
                    .payload       (cell_payload[i]),
                    .le            (cell_le[i])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk          (aclk),
                    .ctrl          (ctrl),
                    .new_key       (new_key),
                    .new_payload   (new_payload),
                    .left_key      (cell_key[i-1]),
                    .left_payload  (cell_payload[i-1]),
                    .left_le       (cell_le[i-1]),
                    .right_key     (cell_key[i+1]),
                    .right_payload (cell_payload[i+1]),
                    .occupied      (cell_occ[i]),
                    .key           (cell_key[i]),
                    .payload       (cell_payload[i]),
                    .le            (cell_le[i])
                );
            end
        end
    endgenerate

    always_comb begin
        count_next       = count_reg;
        status_next      = status_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        if (accept) begin
            out_key_next     = '0;
            out_payload_next = '0;
            if (s_tuser == REQ_ENQ) begin
                if (full) begin
                    status_next = ST_DROPPED;
                end else begin
                    status_next = ST_ENQUEUED;
                    count_next  = count_reg + count_t'(1);
                end
            end else begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next      = ST_DEQUEUED;
                    out_key_next     = cell_key[0];
                    out_payload_next = cell_payload[0];
                    count_next       = count_reg - count_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg      <= status_next;
        out_key_reg     <= out_key_next;
        out_payload_reg <= out_payload_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_FIELD_BITS){1'b0}},
                       count_reg, out_payload_reg, out_key_reg};

endmodule

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic                aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::key_t       new_key,
    input  spq_pkg::payload_t   new_payload,
    input  spq_pkg::key_t       left_key,
    input  spq_pkg::payload_t   left_payload,
    input  logic                left_le,
    input  spq_pkg::key_t       right_key,
    input  spq_pkg::payload_t   right_payload,
    input  logic                occupied,
    output spq_pkg::key_t       key,
    output spq_pkg::payload_t   payload,
    output logic                le
);
    import spq_pkg::*;

    key_t     key_reg, key_next;
    payload_t payload_reg, payload_next;

    // The held entry stays put when its key is not larger than the new one.
    assign le = occupied && (key_reg <= new_key);

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.push) begin
            if (!le) begin
                if (left_le) begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end else begin
                    key_next     = left_key;
                    payload_next = left_payload;
                end
            end
        end else if (ctrl.pop) begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

>>> rtl/core/spq_checker.sv
`timescale 1ns / 1ps

module spq_port_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [spq_pkg::M_DATA_BITS-1:0]     m_tdata,
    input logic [spq_pkg::STATUS_BITS-1:0]     m_tuser
);
    import spq_pkg::*;

    localparam int OCC_LSB = KEY_BITS + PAYLOAD_BITS;

    logic [CNT_BITS-1:0] occ;
    assign occ = m_tdata[OCC_LSB+CNT_BITS-1:OCC_LSB];

    // No result may be pending right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only a dequeued entry carries a key and payload.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DEQUEUED) |-> m_tdata[OCC_LSB-1:0] == '0)
        else $error("key or payload set without a dequeue");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= CNT_BITS'(DEPTH))
        else $error("occupancy beyond capacity");

    a_status_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser != ST_DROPPED) || (occ == CNT_BITS'(DEPTH)))
                  && ((m_tuser != ST_EMPTY) || (occ == '0))
                  && ((m_tuser != ST_ENQUEUED) || (occ != '0)))
        else $error("status disagrees with occupancy");

endmodule

bind stable_priority_queue spq_port_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [spq_pkg::S_DATA_BITS-1:0]     s_tdata,   // item_key, item_payload
    input  logic                                s_tuser,   // req_type
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [spq_pkg::M_DATA_BITS-1:0]     m_tdata,   // out_key, out_payload, occupancy
    input  logic [spq_pkg::STATUS_BITS-1:0]     m_tuser,   // status
    output int                                  errors,
    output int                                  pending
);
    import spq_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        key_t                   key;
        payload_t               payload;
        count_t                 occupancy;
    } reply_t;

    // Shadow copy of the sorted queue.
    key_t     held_keys [DEPTH];
    payload_t held_pays [DEPTH];
    count_t   held_count;

    reply_t expected_replies[$];

    task automatic apply_request(input logic req, input key_t k, input payload_t p,
                                 output reply_t r);
        int pos;
        r = '0;
        if (req == REQ_ENQ) begin
            if (held_count >= DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                // The new entry goes behind every entry with a smaller or equal key.
                pos = 0;
                while (pos < int'(held_count) && held_keys[pos] <= k)
                    pos++;
                for (int i = int'(held_count); i > pos; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_pays[i] = held_pays[i-1];
                end
                held_keys[pos] = k;
                held_pays[pos] = p;
                held_count     = held_count + 1'b1;
                r.status       = ST_ENQUEUED;
            end
        end else begin
            if (held_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key     = held_keys[0];
                r.payload = held_pays[0];
                for (int i = 1; i < int'(held_count); i++) begin
                    held_keys[i-1] = held_keys[i];
                    held_pays[i-1] = held_pays[i];
                end
                held_count = held_count - 1'b1;
                r.status   = ST_DEQUEUED;
            end
        end
        r.occupancy = held_count;
    endtask

    task automatic flag_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            held_count = '0;
            expected_replies.delete();
            errors  = 0;
            pending <= 0;
        end else begin
            // Results leaving at this edge belong to items taken at earlier edges,
            // so the output side is checked before the new item is predicted.
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.key       = m_tdata[KEY_BITS-1:0];
                got.payload   = m_tdata[KEY_BITS +: PAYLOAD_BITS];
                got.occupancy = m_tdata[KEY_BITS+PAYLOAD_BITS +: CNT_BITS];
                if (expected_replies.size() == 0) begin
                    $display("%0t: no result expected, got status %h key %h payload %h occ %h",
                             $time, got.status, got.key, got.payload, got.occupancy);
                    errors++;
                end else begin
                    want = expected_replies[0];
                    expected_replies.delete(0);
                    flag_field("status", 32'(want.status), 32'(got.status));
                    flag_field("out_key", 32'(want.key), 32'(got.key));
                    flag_field("out_payload", 32'(want.payload), 32'(got.payload));
                    flag_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[KEY_BITS-1:0],
                              s_tdata[KEY_BITS +: PAYLOAD_BITS], want);
                expected_replies.insert(expected_replies.size(), want);
            end
            pending <= expected_replies.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;   // item_key, item_payload
    logic                   s_tuser  = 1'b0; // req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;         // out_key, out_payload, occupancy
    logic [STATUS_BITS-1:0] m_tuser;         // status

    int   errors;
    int   pending;
    logic tx_idle_on  = 1'b1;
    logic rx_idle_on  = 1'b1;
    logic rx_hold_req = 1'b0;

    stable_priority_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    spq_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one item; s_tvalid stays high afterwards unless a gap follows.
    task automatic offer_request(input logic req, input key_t k, input payload_t p);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_DATA_BITS'({p, k});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Receiver: random stalls, plus one long hold-off to back up the input side.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (rx_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int       mode;
        int       enq_pct;
        key_t     kbase;
        key_t     k;
        payload_t p;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty dequeue, extreme fields, equal keys, full queue.
        offer_request(REQ_DEQ, 8'hFF, 32'hFFFF_FFFF);
        offer_request(REQ_ENQ, 8'hFF, 32'hFFFF_FFFF);
        offer_request(REQ_ENQ, 8'h00, 32'h0000_0000);
        offer_request(REQ_ENQ, 8'h80, 32'hAAAA_0001);
        offer_request(REQ_ENQ, 8'h80, 32'h5555_0002);
        offer_request(REQ_ENQ, 8'h80, 32'hAAAA_0003);
        repeat (3) offer_request(REQ_DEQ, 8'h00, 32'h0);
        for (int i = 0; i < 14; i++)
            offer_request(REQ_ENQ, 8'(i * 37), $urandom);
        offer_request(REQ_ENQ, 8'h00, 32'h1234_5678);
        offer_request(REQ_DEQ, 8'h00, 32'h0);

        // Random part: phases that lean toward filling, draining or neither.
        mode  = 0;
        kbase = '0;
        for (int n = 0; n < 1650; n++) begin
            if (n % 60 == 0) begin
                mode  = $urandom_range(0, 2);
                kbase = key_t'($urandom_range(0, 255));
            end
            if (n == 300)
                rx_hold_req <= 1'b1;
            if (n == 900)
                wait_until_drained();
            if (n == 1500) begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            enq_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            // Half the keys come from a narrow window so that equal keys are common.
            if ($urandom_range(0, 1))
                k = key_t'($urandom_range(0, 255));
            else
                k = kbase + key_t'($urandom_range(0, 3));
            p = $urandom;
            offer_request(($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ, k, p);
        end

        wait_until_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
rtl/core/spq_checker.sv
tb/spq_checker.sv
tb/tb_top.sv
